/* design/pingpong_audio_sample_feeder_defines.svh */
// Assertion macros for the ping-pong sample feeder checker.
// No dependencies; included by the checker file.
`ifndef PINGPONG_AUDIO_SAMPLE_FEEDER_DEFINES_SVH
`define PINGPONG_AUDIO_SAMPLE_FEEDER_DEFINES_SVH

// ante in one cycle implies cons in the next; rst aborts the check
`define PASF_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: next-cycle check failed");

// ante implies cons in the same cycle
`define PASF_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: same-cycle check failed");

`endif

/* design/pasf_pkg.sv */
// Shared types and constants for the ping-pong audio sample feeder.
// No dependencies.
package pasf_pkg;

   localparam int ADDR_W      = 9;
   localparam int SAMPLE_W    = 8;
   localparam int REQ_TDATA_W = 24;
   localparam int REQ_TUSER_W = 2;
   localparam int RSP_TDATA_W = 24;
   // first unused bit of rsp_tdata
   localparam int RSP_PAD_LSB = 2 * SAMPLE_W + 2;

   typedef enum logic [1:0] {
      FUNC_TICK   = 2'd0,
      FUNC_WRITE  = 2'd1,
      FUNC_ACK    = 2'd2,
      FUNC_REWIND = 2'd3
   } func_type;

   typedef struct packed {
      func_type              func;
      logic [ADDR_W-1:0]     addr;
      logic [SAMPLE_W-1:0]   data;
      logic                  half;
   } item_type;

   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } store_ctl_type;

endpackage

/* design/pasf_sample_store.sv */
// Sample byte store: one write port, two read ports with registered data.
// Depends on pasf_pkg.
module pasf_sample_store #(
   parameter int DEPTH = 512,
   parameter int AW    = 9
) (
   input  logic                           clock,
   input  pasf_pkg::store_ctl_type        ctl,
   input  logic [AW-1:0]                  wr_addr,
   input  logic [pasf_pkg::SAMPLE_W-1:0]  wr_data,
   input  logic [AW-1:0]                  rd_addr0,
   input  logic [AW-1:0]                  rd_addr1,
   output logic [pasf_pkg::SAMPLE_W-1:0]  rd_data0,
   output logic [pasf_pkg::SAMPLE_W-1:0]  rd_data1
);

   logic [pasf_pkg::SAMPLE_W-1:0] store_mem [DEPTH];
   logic [pasf_pkg::SAMPLE_W-1:0] rd_data0_ff;
   logic [pasf_pkg::SAMPLE_W-1:0] rd_data1_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         store_mem[wr_addr] <= wr_data;
      end
      if (ctl.rd_en) begin
         rd_data0_ff <= store_mem[rd_addr0];
         rd_data1_ff <= store_mem[rd_addr1];
      end
   end

   assign rd_data0 = rd_data0_ff;
   assign rd_data1 = rd_data1_ff;

endmodule

/* design/pingpong_audio_sample_feeder.sv */
// Ping-pong audio sample feeder, top level. Depends on pasf_pkg, pasf_sample_store.
// Pipeline has three stages: input register, store read / state update,
// result register.
// Throughput: one item per cycle unless rsp_tready stalls the result, set by the
// store's single write port and registered read port pair. Reset clears index,
// flags, held samples and all valid bits; the store contents are not cleared.
module pingpong_audio_sample_feeder #(
   parameter int HALF_DEPTH = 256
) (
   input  logic                              clock,
   input  logic                              reset,
   // req_tdata: addr[8:0], data[16:9], half[17], zero above
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [pasf_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // req_tuser: func[1:0]
   input  logic [pasf_pkg::REQ_TUSER_W-1:0]  req_tuser,
   // rsp_tdata: left_sample[7:0], right_sample[15:8], low_half_empty[16],
   //            high_half_empty[17], zero above
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [pasf_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [0:0]                        csr_data
);

   localparam int STORE_DEPTH = 2 * HALF_DEPTH;
   localparam int IW  = $clog2(STORE_DEPTH);
   localparam int IXW = IW + 1;
   localparam int XW  = (IXW > pasf_pkg::ADDR_W) ? IXW : pasf_pkg::ADDR_W;
   localparam logic [IXW-1:0] HALF_X  = IXW'(HALF_DEPTH);
   localparam logic [IXW-1:0] STORE_X = IXW'(STORE_DEPTH);
   localparam logic [XW-1:0]  STORE_A = XW'(STORE_DEPTH);

   localparam int SW = pasf_pkg::SAMPLE_W;

   pasf_pkg::item_type       req_item;
   pasf_pkg::item_type       s1_item_ff;
   logic                     s1_valid_ff;
   logic                     s2_valid_ff, s2_tick_ff, s2_low_ff, s2_high_ff;
   logic                     rsp_valid_ff, rsp_low_ff, rsp_high_ff;
   logic [SW-1:0]            left_hold_ff, right_hold_ff;
   logic [SW-1:0]            left_hold_in, right_hold_in;
   logic [IW-1:0]            read_index_ff, read_index_in;
   logic                     low_flag_ff, high_flag_ff, low_flag_in, high_flag_in;
   logic                     stereo_ff;
   logic                     en0, en1, en2;
   logic [IXW-1:0]           idx_before, idx_after, idx_next1;
   logic                     low_set, high_wrap;
   logic [XW-1:0]            addr_x;
   logic                     addr_ok;
   logic [IW-1:0]            rd_addr0, rd_addr1;
   logic [SW-1:0]            rd_data0, rd_data1;
   pasf_pkg::store_ctl_type  store_ctl;

   assign req_item.func = pasf_pkg::func_type'(req_tuser[1:0]);
   assign req_item.addr = req_tdata[8:0];
   assign req_item.data = req_tdata[16:9];
   assign req_item.half = req_tdata[17];

   // stage enables, back to front
   assign en2 = !rsp_valid_ff || rsp_tready;
   assign en1 = !s2_valid_ff || en2;
   assign en0 = !s1_valid_ff || en1;
   assign req_tready = en0;
   assign csr_ready  = 1'b1;

   // index arithmetic for a tick
   always_comb begin
      idx_before = {1'b0, read_index_ff};
      idx_after  = idx_before + (stereo_ff ? IXW'(2) : IXW'(1));
      idx_next1  = idx_before + IXW'(1);
      low_set    = (idx_before < HALF_X) && (idx_after >= HALF_X);
      high_wrap  = idx_after >= STORE_X;
      rd_addr0   = read_index_ff;
      // right byte wraps to address zero at the end of the store
      rd_addr1   = (idx_next1 >= STORE_X) ? '0 : idx_next1[IW-1:0];
      addr_x     = XW'(s1_item_ff.addr);
      addr_ok    = addr_x < STORE_A;
   end

   always_comb begin
      read_index_in = read_index_ff;
      low_flag_in   = low_flag_ff;
      high_flag_in  = high_flag_ff;
      case (s1_item_ff.func)
         pasf_pkg::FUNC_TICK: begin
            read_index_in = high_wrap ? IW'(idx_after - STORE_X) : idx_after[IW-1:0];
            if (low_set) begin
               low_flag_in = 1'b1;
            end
            if (high_wrap) begin
               high_flag_in = 1'b1;
            end
         end
         pasf_pkg::FUNC_WRITE: begin
         end
         pasf_pkg::FUNC_ACK: begin
            if (s1_item_ff.half) begin
               high_flag_in = 1'b0;
            end else begin
               low_flag_in = 1'b0;
            end
         end
         pasf_pkg::FUNC_REWIND: begin
            read_index_in = '0;
            low_flag_in   = 1'b0;
            high_flag_in  = 1'b0;
         end
         default: begin
         end
      endcase
   end

   assign store_ctl.wr_en = en1 && s1_valid_ff && (s1_item_ff.func == pasf_pkg::FUNC_WRITE)
                            && addr_ok;
   assign store_ctl.rd_en = en1 && s1_valid_ff && (s1_item_ff.func == pasf_pkg::FUNC_TICK);

   pasf_sample_store #(
      .DEPTH (STORE_DEPTH),
      .AW    (IW)
   ) u_store (
      .clock    (clock),
      .ctl      (store_ctl),
      .wr_addr  (addr_x[IW-1:0]),
      .wr_data  (s1_item_ff.data),
      .rd_addr0 (rd_addr0),
      .rd_addr1 (rd_addr1),
      .rd_data0 (rd_data0),
      .rd_data1 (rd_data1)
   );

   always_comb begin
      left_hold_in  = left_hold_ff;
      right_hold_in = right_hold_ff;
      if (s2_tick_ff) begin
         left_hold_in  = rd_data0;
         right_hold_in = stereo_ff ? rd_data1 : rd_data0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         s2_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         read_index_ff <= '0;
         low_flag_ff   <= 1'b0;
         high_flag_ff  <= 1'b0;
         left_hold_ff  <= '0;
         right_hold_ff <= '0;
         stereo_ff     <= 1'b0;
      end else begin
         if (csr_valid) begin
            stereo_ff <= csr_data[0];
         end
         if (en0) begin
            s1_valid_ff <= req_tvalid;
         end
         if (en1) begin
            s2_valid_ff <= s1_valid_ff;
            if (s1_valid_ff) begin
               read_index_ff <= read_index_in;
               low_flag_ff   <= low_flag_in;
               high_flag_ff  <= high_flag_in;
            end
         end
         if (en2) begin
            rsp_valid_ff <= s2_valid_ff;
            if (s2_valid_ff) begin
               left_hold_ff  <= left_hold_in;
               right_hold_ff <= right_hold_in;
            end
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (en0 && req_tvalid) begin
         s1_item_ff <= req_item;
      end
      if (en1 && s1_valid_ff) begin
         s2_tick_ff <= (s1_item_ff.func == pasf_pkg::FUNC_TICK);
         s2_low_ff  <= low_flag_in;
         s2_high_ff <= high_flag_in;
      end
      if (en2 && s2_valid_ff) begin
         rsp_low_ff  <= s2_low_ff;
         rsp_high_ff <= s2_high_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(pasf_pkg::RSP_TDATA_W - pasf_pkg::RSP_PAD_LSB)'(0),
                        rsp_high_ff, rsp_low_ff, right_hold_ff, left_hold_ff};

endmodule

/* design/pasf_checker.sv */
// Port-level checks for the ping-pong audio sample feeder, bound to the top.
// Depends on pasf_pkg and pingpong_audio_sample_feeder_defines.svh.
`include "pingpong_audio_sample_feeder_defines.svh"

module pasf_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [pasf_pkg::RSP_TDATA_W-1:0]  rsp_tdata
);

   localparam int TW      = pasf_pkg::RSP_TDATA_W;
   localparam int PAD_LSB = pasf_pkg::RSP_PAD_LSB;

   logic rsp_stall;

   assign rsp_stall = rsp_tvalid && !rsp_tready;

   // a stalled result stays offered and unchanged
   `PASF_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_tvalid && $stable(rsp_tdata))

   // reset empties the pipeline
   `PASF_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_tvalid)

   // unused result bits stay zero
   `PASF_ASSERT_NOW(a_rsp_pad, clock, reset, rsp_tvalid, rsp_tdata[TW-1:PAD_LSB] == '0)

endmodule

bind pingpong_audio_sample_feeder pasf_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
